FILE: hdl/cbq_pkg.sv
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared codes and fixed formats of the cascaded biquad filter core.
// ----------------------------------------------------------------------------
`default_nettype none
package cbq_pkg;

	localparam logic [1:0] FUNC_FILTER = 2'd0;
	localparam logic [1:0] FUNC_COEF   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam int SLOTS = 6;
	localparam logic [2:0] SLOT_GAIN = 3'd0;
	localparam logic [2:0] SLOT_B0   = 3'd1;
	localparam logic [2:0] SLOT_B1   = 3'd2;
	localparam logic [2:0] SLOT_B2   = 3'd3;
	localparam logic [2:0] SLOT_A1   = 3'd4;
	localparam logic [2:0] SLOT_A2   = 3'd5;

	localparam int ACC_WIDTH = 40;
	localparam int GB_WIDTH  = 24;
	localparam int FRAC      = 16;
	localparam int HALF      = 1 << (FRAC - 1);

endpackage
`default_nettype wire

FILE: hdl/cbq_coef_ram.sv
// ----------------------------------------------------------------------------
// cbq_coef_ram
// Coefficient store, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module cbq_coef_ram #(
	parameter int DEPTH = 48,
	parameter int WIDTH = 20,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/cbq_state_ram.sv
// ----------------------------------------------------------------------------
// cbq_state_ram
// Section delay state store; per-entry valid bits let one clear empty all entries.
// ----------------------------------------------------------------------------
`default_nettype none
module cbq_state_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 40,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clr,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_q;
	logic             rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[raddr];
			if (clr) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// entries never written since the last clear read as zero
	assign rdata = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

FILE: hdl/cbq_mult.sv
// ----------------------------------------------------------------------------
// cbq_mult
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module cbq_mult #(
	parameter int AW = 24,
	parameter int BW = 20
) (
	input  wire logic                 clk,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0]   p
);

	always_ff @(posedge clk) begin
		p <= (AW+BW)'(a) * (AW+BW)'(b);
	end

endmodule
`default_nettype wire

FILE: hdl/cascaded_biquad_iir_filter_core.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter_core
// Cascade of transposed direct form II biquads over one shared multiplier.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser carries func (0 filter, 1 coefficient write,
// 2 clear state). A filter transaction returns one result on m_*; coefficient
// writes and clears return nothing and complete in the accept cycle.
// Each section runs one sequence of steps on one multiplier: six coefficient
// reads and two state reads from memories with one registered read port,
// eight products, two state write-backs. A sample runs this sequence once
// for each of N sections, N being active_sections; the next transaction is
// taken from the cycle after the result is loaded into the output register.
// cfg_wr_en/cfg_wr_data set active_sections (0 acts as 1, values above
// MAX_SECTIONS as MAX_SECTIONS); write only while idle.
// Reset sets active_sections to 1 and zeroes all delay state; coefficients
// are undefined until written. If m_tready stays low, the finished result
// waits in the output register and the core holds the next result until it
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module cascaded_biquad_iir_filter_core #(
	parameter int MAX_SECTIONS = 8,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 20,
	localparam int IN_BITS  = SAMPLE_WIDTH + 6 + COEF_WIDTH,
	localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_DW   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [3:0]        cfg_wr_data,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// sample_in, coef_section, coef_slot, coef_value
	input  wire logic [IN_DW-1:0]  s_tdata,
	// func
	input  wire logic [1:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// sample_out
	output logic [OUT_DW-1:0]      m_tdata,
	// saturated
	output logic                   m_tuser
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int CW    = COEF_WIDTH;
	localparam int ACCW  = cbq_pkg::ACC_WIDTH;
	localparam int GBW   = cbq_pkg::GB_WIDTH;
	localparam int FR    = cbq_pkg::FRAC;
	localparam int MA    = (GBW > CW) ? GBW : CW;
	localparam int MB    = (CW > SW) ? CW : SW;
	localparam int PW    = MA + MB;
	localparam int SUMW  = ((PW > ACCW) ? PW : ACCW) + 2;
	localparam int RW    = ((PW > FR + GBW) ? PW : FR + GBW) + 1;
	localparam int YW    = ((ACCW > FR + SW) ? ACCW : FR + SW) + 1;
	localparam int SECW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int ACTW  = $clog2(MAX_SECTIONS + 1);
	localparam int CDEP  = MAX_SECTIONS * cbq_pkg::SLOTS;
	localparam int CAW   = $clog2(CDEP);
	localparam int SDEP  = 2 * MAX_SECTIONS;
	localparam int SAW   = SECW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [3:0] K_RD_G   = 4'd0;
	localparam logic [3:0] K_RD_B0  = 4'd1;
	localparam logic [3:0] K_MUL_B0 = 4'd2;
	localparam logic [3:0] K_MUL_B1 = 4'd3;
	localparam logic [3:0] K_MUL_B2 = 4'd4;
	localparam logic [3:0] K_MUL_X0 = 4'd5;
	localparam logic [3:0] K_MUL_X1 = 4'd6;
	localparam logic [3:0] K_MUL_X2 = 4'd7;
	localparam logic [3:0] K_MUL_A1 = 4'd8;
	localparam logic [3:0] K_MUL_A2 = 4'd9;
	localparam logic [3:0] K_WR_S1  = 4'd10;

	logic [1:0]             state_q;
	logic [3:0]             step_q;
	logic [SECW-1:0]        sec_q;
	logic [ACTW-1:0]        act_q;
	logic signed [SW-1:0]   x_q;
	logic signed [SW-1:0]   y_q;
	logic                   clip_q;
	logic signed [CW-1:0]   g_q;
	logic signed [CW-1:0]   a1_q;
	logic signed [CW-1:0]   a2_q;
	logic signed [GBW-1:0]  gb0_q;
	logic signed [GBW-1:0]  gb1_q;
	logic signed [GBW-1:0]  gb2_q;
	logic signed [ACCW-1:0] s0_q;
	logic signed [ACCW-1:0] s1_q;
	logic signed [SUMW-1:0] t0_q;
	logic signed [SUMW-1:0] t1_q;
	logic                   out_valid_q;
	logic [SW-1:0]          out_q;
	logic                   out_sat_q;

	logic                   in_acc;
	logic signed [SW-1:0]   in_sample;
	logic [2:0]             in_sec;
	logic [2:0]             in_slot;
	logic [CW-1:0]          in_val;
	logic                   last_sec;
	logic                   out_free;

	logic                   coef_we;
	logic [CAW-1:0]         coef_waddr;
	logic [CAW-1:0]         coef_raddr;
	logic [CW-1:0]          coef_rdata;
	logic [2:0]             rd_slot;

	logic                   st_we;
	logic [SAW-1:0]         st_waddr;
	logic [SAW-1:0]         st_raddr;
	logic [ACCW-1:0]        st_wdata;
	logic [ACCW-1:0]        st_rdata;

	logic signed [MA-1:0]   mul_a;
	logic signed [MB-1:0]   mul_b;
	logic signed [PW-1:0]   prod;

	logic signed [RW-1:0]   gsum;
	logic signed [GBW-1:0]  gb_sat;
	logic signed [ACCW-1:0] acc;
	logic signed [YW-1:0]   ysum;
	logic signed [SW-1:0]   y_sat;
	logic                   y_clip;
	logic signed [ACCW-1:0] s_new;

	function automatic logic signed [ACCW-1:0] sat_acc(input logic signed [SUMW-1:0] v);
		logic [SUMW-ACCW:0] top;
		top = v[SUMW-1:ACCW-1];
		if ((&top) || !(|top)) begin
			return v[ACCW-1:0];
		end
		return v[SUMW-1] ? {1'b1, {(ACCW-1){1'b0}}} : {1'b0, {(ACCW-1){1'b1}}};
	endfunction

	assign in_sample = s_tdata[SW-1:0];
	assign in_sec    = s_tdata[SW+2:SW];
	assign in_slot   = s_tdata[SW+5:SW+3];
	assign in_val    = s_tdata[SW+6+CW-1:SW+6];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign last_sec = (int'(sec_q) + 1 >= int'(act_q));
	assign out_free = !out_valid_q || m_tready;

	assign coef_we = in_acc && (s_tuser == cbq_pkg::FUNC_COEF) &&
		(int'(in_sec) < MAX_SECTIONS) && (int'(in_slot) < cbq_pkg::SLOTS);
	assign coef_waddr = CAW'(int'(in_sec) * cbq_pkg::SLOTS + int'(in_slot));

	always_comb begin
		case (step_q)
			K_RD_G:   rd_slot = cbq_pkg::SLOT_GAIN;
			K_RD_B0:  rd_slot = cbq_pkg::SLOT_B0;
			K_MUL_B0: rd_slot = cbq_pkg::SLOT_B1;
			K_MUL_B1: rd_slot = cbq_pkg::SLOT_B2;
			K_MUL_B2: rd_slot = cbq_pkg::SLOT_A1;
			K_MUL_X0: rd_slot = cbq_pkg::SLOT_A2;
			default:  rd_slot = cbq_pkg::SLOT_GAIN;
		endcase
	end
	assign coef_raddr = CAW'(int'(sec_q) * cbq_pkg::SLOTS + int'(rd_slot));

	cbq_coef_ram #(.DEPTH(CDEP), .WIDTH(CW), .AW(CAW)) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (in_val),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	assign st_raddr = {sec_q, (step_q != K_RD_G)};
	assign st_we    = (state_q == ST_RUN) && ((step_q == K_MUL_A2) || (step_q == K_WR_S1));
	assign st_waddr = {sec_q, (step_q == K_WR_S1)};
	assign st_wdata = s_new;

	cbq_state_ram #(.DEPTH(SDEP), .WIDTH(ACCW), .AW(SAW)) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (in_acc && (s_tuser == cbq_pkg::FUNC_CLEAR)),
		.we     (st_we),
		.waddr  (st_waddr),
		.wdata  (st_wdata),
		.raddr  (st_raddr),
		.rdata  (st_rdata)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q) inside
			K_MUL_B0, K_MUL_B1, K_MUL_B2: begin
				mul_a = MA'(g_q);
				mul_b = MB'($signed(coef_rdata));
			end
			K_MUL_X0: begin
				mul_a = MA'(gb0_q);
				mul_b = MB'(x_q);
			end
			K_MUL_X1: begin
				mul_a = MA'(gb1_q);
				mul_b = MB'(x_q);
			end
			K_MUL_X2: begin
				mul_a = MA'(gb2_q);
				mul_b = MB'(x_q);
			end
			K_MUL_A1: begin
				mul_a = MA'(a1_q);
				mul_b = MB'(y_q);
			end
			K_MUL_A2: begin
				mul_a = MA'(a2_q);
				mul_b = MB'(y_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	cbq_mult #(.AW(MA), .BW(MB)) u_mult (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// g*b rounded to Q.16 and clipped to the effective numerator width
	always_comb begin
		logic [RW-FR-GBW:0] gtop;
		gsum = RW'(prod) + RW'(cbq_pkg::HALF);
		gtop = gsum[RW-1:FR+GBW-1];
		if ((&gtop) || !(|gtop)) begin
			gb_sat = gsum[FR+GBW-1:FR];
		end else begin
			gb_sat = gsum[RW-1] ? {1'b1, {(GBW-1){1'b0}}} : {1'b0, {(GBW-1){1'b1}}};
		end
	end

	// section output: acc = gb0*x + s0, then round to the sample format
	always_comb begin
		logic [YW-FR-SW:0] ytop;
		acc  = sat_acc(SUMW'(prod) + SUMW'(s0_q));
		ysum = YW'(acc) + YW'(cbq_pkg::HALF);
		ytop = ysum[YW-1:FR+SW-1];
		if ((&ytop) || !(|ytop)) begin
			y_sat  = ysum[FR+SW-1:FR];
			y_clip = 1'b0;
		end else begin
			y_sat  = ysum[YW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
			y_clip = 1'b1;
		end
	end

	assign s_new = sat_acc(((step_q == K_WR_S1) ? t1_q : t0_q) - SUMW'(prod));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= K_RD_G;
			sec_q       <= '0;
			act_q       <= ACTW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_wr_data == 4'd0) begin
					act_q <= ACTW'(1);
				end else if (int'(cfg_wr_data) > MAX_SECTIONS) begin
					act_q <= ACTW'(MAX_SECTIONS);
				end else begin
					act_q <= ACTW'(cfg_wr_data);
				end
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_tuser == cbq_pkg::FUNC_FILTER)) begin
						state_q <= ST_RUN;
						step_q  <= K_RD_G;
						sec_q   <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == K_WR_S1) begin
						step_q <= K_RD_G;
						if (last_sec) begin
							state_q <= ST_DONE;
						end else begin
							sec_q <= sec_q + SECW'(1);
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser == cbq_pkg::FUNC_FILTER)) begin
			x_q    <= in_sample;
			clip_q <= 1'b0;
		end
		if (state_q == ST_RUN) begin
			case (step_q)
				K_RD_B0: begin
					g_q  <= $signed(coef_rdata);
					s0_q <= $signed(st_rdata);
				end
				K_MUL_B0: s1_q  <= $signed(st_rdata);
				K_MUL_B1: gb0_q <= gb_sat;
				K_MUL_B2: gb1_q <= gb_sat;
				K_MUL_X0: begin
					gb2_q <= gb_sat;
					a1_q  <= $signed(coef_rdata);
				end
				K_MUL_X1: begin
					a2_q   <= $signed(coef_rdata);
					y_q    <= y_sat;
					clip_q <= clip_q | y_clip;
				end
				K_MUL_X2: t0_q <= SUMW'(prod) + SUMW'(s1_q);
				K_MUL_A1: t1_q <= SUMW'(prod);
				K_WR_S1:  x_q  <= y_q;
				default: ;
			endcase
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q     <= x_q;
			out_sat_q <= clip_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DW'(out_q);
	assign m_tuser  = out_sat_q;

endmodule
`default_nettype wire
